### design/sorted_list_insert_remove_defines.svh
// Assertion macros shared by the checker of the sorted list block.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef SORTED_LIST_INSERT_REMOVE_DEFINES_SVH
`define SORTED_LIST_INSERT_REMOVE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SLI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/sli_pkg.sv
// Shared types and constants of the sorted list block.
// No dependencies.
package sli_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned POS_W         = 5;
  localparam int unsigned HELD_W        = 5;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_DUMP   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

endpackage

### design/sli_if.sv
// Valid/ready channels of the sorted list block: command in, result out.
// Depends on sli_pkg.
interface sli_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        func;
  logic signed [sli_pkg::DATA_W-1:0] value;
  logic [sli_pkg::POS_W-1:0]         position;

  modport source (output valid, func, value, position, input ready);
  modport sink   (input valid, func, value, position, output ready);
endinterface

interface sli_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic signed [sli_pkg::DATA_W-1:0] element;
  logic [sli_pkg::HELD_W-1:0]        held;
  logic                              last;

  modport source (output valid, status, element, held, last, input ready);
  modport sink   (input valid, status, element, held, last, output ready);
endinterface

### design/sorted_list_insert_remove.sv
// Sorted list: insert keeps ascending order, remove at 1-based position, dump.
// Single-port store with registered read and one shared compare. Insert shifts
// each entry above the new value up from the end; remove shifts the entries
// after the position down; dump emits each entry, waiting while the result
// channel is busy; full, bad position, empty answer directly. One item at a time.
// Reset clears the count and control; store contents are undefined until written.
module sorted_list_insert_remove #(
  parameter int unsigned DEPTH = sli_pkg::DEPTH_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sli_in_if.sink    in_i,
  sli_out_if.source out_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned IW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (IW > sli_pkg::POS_W) ? IW : sli_pkg::POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_REM_RD,
    S_REM_WR,
    S_DMP_RD,
    S_DMP_EMIT,
    S_RESP
  } state_e;

  state_e                            state_q;
  logic [IW-1:0]                     count_q;
  logic [IW-1:0]                     idx_q;
  logic signed [sli_pkg::DATA_W-1:0] val_q;
  sli_pkg::status_e                  status_q;

  logic                              out_valid_q;
  sli_pkg::status_e                  out_status_q;
  logic signed [sli_pkg::DATA_W-1:0] out_element_q;
  logic [sli_pkg::HELD_W-1:0]        out_held_q;
  logic                              out_last_q;

  logic signed [sli_pkg::DATA_W-1:0] store_q [DEPTH];
  logic signed [sli_pkg::DATA_W-1:0] rdata_q;

  logic                              mem_we;
  logic                              mem_re;
  logic [AW-1:0]                     mem_waddr;
  logic [AW-1:0]                     mem_raddr;
  logic signed [sli_pkg::DATA_W-1:0] mem_wdata;

  logic [IW-1:0] idx_inc;
  logic [IW-1:0] idx_dec;
  logic          greater;
  logic          rem_done;
  logic          out_free;
  logic          pos_bad;
  logic          dmp_last;

  assign idx_inc  = IW'(idx_q + 1'b1);
  assign idx_dec  = IW'(idx_q - 1'b1);
  assign greater  = rdata_q > val_q;
  assign rem_done = idx_inc >= count_q;
  assign out_free = !out_valid_q || out_o.ready;
  assign dmp_last = idx_inc == count_q;
  assign pos_bad  = (in_i.position == '0) || (CW'(in_i.position) > CW'(count_q));

  assign in_i.ready    = state_q == S_IDLE;
  assign out_o.valid   = out_valid_q;
  assign out_o.status  = out_status_q;
  assign out_o.element = out_element_q;
  assign out_o.held    = out_held_q;
  assign out_o.last    = out_last_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = idx_q[AW-1:0];
    mem_raddr = idx_q[AW-1:0];
    mem_wdata = val_q;
    case (state_q)
      S_INS_RD: begin
        if (idx_q == '0) begin
          mem_we = 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_dec[AW-1:0];
        end
      end
      S_INS_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = greater ? rdata_q : val_q;
      end
      S_REM_RD: begin
        if (!rem_done) begin
          mem_re    = 1'b1;
          mem_raddr = idx_inc[AW-1:0];
        end
      end
      S_REM_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_q;
      end
      S_DMP_RD: mem_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= store_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            val_q <= in_i.value;
            case (in_i.func)
              sli_pkg::FUNC_INSERT: begin
                if (count_q == IW'(DEPTH)) begin
                  status_q <= sli_pkg::ST_FULL;
                  state_q  <= S_RESP;
                end else begin
                  idx_q   <= count_q;
                  state_q <= S_INS_RD;
                end
              end
              sli_pkg::FUNC_REMOVE: begin
                if (pos_bad) begin
                  status_q <= sli_pkg::ST_BADPOS;
                  state_q  <= S_RESP;
                end else begin
                  idx_q   <= IW'(in_i.position - 1'b1);
                  state_q <= S_REM_RD;
                end
              end
              sli_pkg::FUNC_DUMP: begin
                if (count_q == '0) begin
                  status_q <= sli_pkg::ST_EMPTY;
                  state_q  <= S_RESP;
                end else begin
                  idx_q   <= '0;
                  state_q <= S_DMP_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_INS_RD: begin
          if (idx_q == '0) begin
            count_q  <= IW'(count_q + 1'b1);
            status_q <= sli_pkg::ST_OK;
            state_q  <= S_RESP;
          end else begin
            state_q <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (greater) begin
            idx_q   <= idx_dec;
            state_q <= S_INS_RD;
          end else begin
            count_q  <= IW'(count_q + 1'b1);
            status_q <= sli_pkg::ST_OK;
            state_q  <= S_RESP;
          end
        end
        S_REM_RD: begin
          if (rem_done) begin
            count_q  <= IW'(count_q - 1'b1);
            status_q <= sli_pkg::ST_OK;
            state_q  <= S_RESP;
          end else begin
            state_q <= S_REM_WR;
          end
        end
        S_REM_WR: begin
          idx_q   <= idx_inc;
          state_q <= S_REM_RD;
        end
        S_DMP_RD: state_q <= S_DMP_EMIT;
        S_DMP_EMIT: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_status_q  <= sli_pkg::ST_OK;
            out_element_q <= rdata_q;
            out_held_q    <= sli_pkg::HELD_W'(count_q);
            out_last_q    <= dmp_last;
            idx_q         <= idx_inc;
            state_q       <= dmp_last ? S_IDLE : S_DMP_RD;
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_status_q  <= status_q;
            out_element_q <= '0;
            out_held_q    <= sli_pkg::HELD_W'(count_q);
            out_last_q    <= 1'b1;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### design/sli_checker.sv
// Port-level checks of the sorted list block, bound to its top level.
// Depends on sli_pkg and sorted_list_insert_remove_defines.svh.
`include "sorted_list_insert_remove_defines.svh"

module sli_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic [1:0]                        in_func_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [1:0]                        out_status_i,
  input logic signed [sli_pkg::DATA_W-1:0] out_element_i,
  input logic [sli_pkg::HELD_W-1:0]        out_held_i,
  input logic                              out_last_i
);

  `SLI_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_status_i) && $stable(out_element_i) && $stable(out_held_i) && $stable(out_last_i), "stalled item changed")
  `SLI_ASSERT_NEXT(a_busy_after_cmd, in_valid_i && in_ready_i && (in_func_i == sli_pkg::FUNC_INSERT || in_func_i == sli_pkg::FUNC_REMOVE || in_func_i == sli_pkg::FUNC_DUMP), !in_ready_i, "ready right after a command")
  `SLI_ASSERT_NOW(a_empty_form, out_valid_i && out_status_i == sli_pkg::ST_EMPTY, out_held_i == '0 && out_element_i == '0 && out_last_i, "malformed empty result")
  `SLI_ASSERT_NOW(a_not_last_ok, out_valid_i && !out_last_i, out_status_i == sli_pkg::ST_OK, "error result not marked last")
  `SLI_ASSERT_NOW(a_error_form, out_valid_i && (out_status_i == sli_pkg::ST_FULL || out_status_i == sli_pkg::ST_BADPOS), out_element_i == '0 && out_last_i, "malformed error result")

endmodule

bind sorted_list_insert_remove sli_checker u_sli_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_func_i    (in_i.func),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_element_i(out_o.element),
  .out_held_i   (out_o.held),
  .out_last_i   (out_o.last)
);

### tb/sli_result_checker.sv
// Result checker for the sorted list block: watches the command and result
// channels, keeps its own copy of the list and compares every result item.
// Depends on sli_pkg and sli_if.
module sli_result_checker #(
  parameter int unsigned DEPTH = sli_pkg::DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sli_in_if           cmd_i,
  sli_out_if          rsp_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  typedef struct {
    sli_pkg::status_e                   status;
    logic signed [sli_pkg::DATA_W-1:0]  element;
    logic [sli_pkg::HELD_W-1:0]         held;
    logic                               last;
  } list_result_t;

  logic signed [sli_pkg::DATA_W-1:0] sorted_q[$];
  list_result_t                      result_q[$];
  list_result_t                      want;
  int unsigned                       mismatch_cnt;
  int unsigned                       checked_cnt;

  function automatic void push_result(sli_pkg::status_e st,
                                      logic signed [sli_pkg::DATA_W-1:0] elem,
                                      int unsigned cnt, logic last);
    list_result_t r;
    r.status  = st;
    r.element = elem;
    r.held    = sli_pkg::HELD_W'(cnt);
    r.last    = last;
    result_q.push_back(r);
  endfunction

  function automatic void apply_command(logic [1:0] func,
                                        logic signed [sli_pkg::DATA_W-1:0] value,
                                        logic [sli_pkg::POS_W-1:0] position);
    int unsigned slot;
    case (func)
      sli_pkg::FUNC_INSERT: begin
        if (sorted_q.size() >= DEPTH) begin
          push_result(sli_pkg::ST_FULL, '0, sorted_q.size(), 1'b1);
        end else begin
          slot = 0;
          // equal values stay ahead of the new one
          while (slot < sorted_q.size() && sorted_q[slot] <= value) slot++;
          sorted_q.insert(slot, value);
          push_result(sli_pkg::ST_OK, '0, sorted_q.size(), 1'b1);
        end
      end
      sli_pkg::FUNC_REMOVE: begin
        if (position == 0 || position > sorted_q.size()) begin
          push_result(sli_pkg::ST_BADPOS, '0, sorted_q.size(), 1'b1);
        end else begin
          sorted_q.delete(position - 1);
          push_result(sli_pkg::ST_OK, '0, sorted_q.size(), 1'b1);
        end
      end
      sli_pkg::FUNC_DUMP: begin
        if (sorted_q.size() == 0) begin
          push_result(sli_pkg::ST_EMPTY, '0, 0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < sorted_q.size(); i++) begin
            push_result(sli_pkg::ST_OK, sorted_q[i], sorted_q.size(),
                        i + 1 == sorted_q.size());
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void report_mismatch(string field, longint exp_v, longint act_v);
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp_v, act_v);
    mismatch_cnt++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sorted_q.delete();
      result_q.delete();
      mismatch_cnt = 0;
      checked_cnt  = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result: status %0d element %0d held %0d last %0d",
                   $time, rsp_i.status, rsp_i.element, rsp_i.held, rsp_i.last);
          mismatch_cnt++;
        end else begin
          want = result_q.pop_front();
          checked_cnt++;
          if (rsp_i.status !== want.status)
            report_mismatch("status", want.status, rsp_i.status);
          if (rsp_i.element !== want.element)
            report_mismatch("element", want.element, rsp_i.element);
          if (rsp_i.held !== want.held)
            report_mismatch("held", want.held, rsp_i.held);
          if (rsp_i.last !== want.last)
            report_mismatch("last", want.last, rsp_i.last);
        end
      end
      if (cmd_i.valid && cmd_i.ready)
        apply_command(cmd_i.func, cmd_i.value, cmd_i.position);
      mismatches_o <= mismatch_cnt;
      pending_o    <= result_q.size();
      checked_o    <= checked_cnt;
    end
  end

endmodule

### tb/tb_sorted_list_insert_remove.sv
// Top of the sorted list testbench: clock, reset, command stimulus, result
// back-pressure, watchdog and verdict. Depends on sli_pkg, sli_if, the block
// and sli_result_checker.
module tb_sorted_list_insert_remove;

  localparam int unsigned DEPTH          = sli_pkg::DEPTH_DEFAULT;
  localparam logic [1:0]  FUNC_UNUSED    = 2'd3;
  localparam int unsigned RX_HOLD_CYCLES = 200;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned SETTLE_CYCLES  = 80;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sli_in_if  in_ch ();
  sli_out_if out_ch ();

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;

  logic        calm         = 1'b0;
  int unsigned rx_hold_reqs = 0;
  int unsigned list_cnt     = 0;
  int unsigned n_insert     = 0;
  int unsigned n_remove     = 0;
  int unsigned n_dump       = 0;
  int unsigned n_unused     = 0;
  int unsigned n_full       = 0;

  always #6 clk_i = ~clk_i;

  sorted_list_insert_remove #(.DEPTH(DEPTH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  sli_result_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (in_ch),
    .rsp_i        (out_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // result side: random stalls, calm stretches and one long hold-off
  initial begin : rx_side
    int unsigned holds_done;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_reqs != holds_done) begin
        holds_done++;
        out_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
      end
      out_ch.ready <= calm || ($urandom_range(99) >= 35);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("no item moved for %0d cycles", STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_item(logic [1:0] func, logic signed [sli_pkg::DATA_W-1:0] value,
                           logic [sli_pkg::POS_W-1:0] position);
    while (!calm && $urandom_range(99) < 35) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= func;
    in_ch.value    <= value;
    in_ch.position <= position;
    do @(posedge clk_i); while (!in_ch.ready);
    case (func)
      sli_pkg::FUNC_INSERT: begin
        n_insert++;
        if (list_cnt < DEPTH) list_cnt++;
        else n_full++;
      end
      sli_pkg::FUNC_REMOVE: begin
        n_remove++;
        if (position != 0 && position <= list_cnt) list_cnt--;
      end
      sli_pkg::FUNC_DUMP: n_dump++;
      default:   n_unused++;
    endcase
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [sli_pkg::DATA_W-1:0] pick_value();
    if ($urandom_range(99) < 50)
      return int'($urandom_range(16)) - 8;
    return $urandom;
  endfunction

  task automatic send_random(int unsigned n, int unsigned ins_pct, int unsigned rem_pct);
    int unsigned r;
    logic [sli_pkg::POS_W-1:0] pos;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < ins_pct) begin
        send_item(sli_pkg::FUNC_INSERT, pick_value(), sli_pkg::POS_W'($urandom));
      end else if (r < ins_pct + rem_pct) begin
        if ($urandom_range(99) < 80)
          pos = sli_pkg::POS_W'($urandom_range((list_cnt == 0) ? 1 : list_cnt, 1));
        else
          pos = sli_pkg::POS_W'($urandom_range((1 << sli_pkg::POS_W) - 1));
        send_item(sli_pkg::FUNC_REMOVE, $urandom, pos);
      end else if (r < 97) begin
        send_item(sli_pkg::FUNC_DUMP, $urandom, sli_pkg::POS_W'($urandom));
      end else begin
        send_item(FUNC_UNUSED, $urandom, sli_pkg::POS_W'($urandom));
      end
    end
  endtask

  initial begin
    in_ch.valid    <= 1'b0;
    in_ch.func     <= sli_pkg::FUNC_INSERT;
    in_ch.value    <= '0;
    in_ch.position <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner cases: empty list, bad positions, value extremes, unused code
    send_item(sli_pkg::FUNC_DUMP, '0, '0);
    send_item(sli_pkg::FUNC_REMOVE, '0, 5'd1);
    send_item(sli_pkg::FUNC_REMOVE, '0, 5'd0);
    send_item(sli_pkg::FUNC_INSERT, 32'sh7fff_ffff, '0);
    send_item(sli_pkg::FUNC_INSERT, 32'sh8000_0000, '1);
    send_item(sli_pkg::FUNC_INSERT, '0, '0);
    send_item(sli_pkg::FUNC_INSERT, '0, '0);
    send_item(sli_pkg::FUNC_INSERT, -32'sd1, '0);
    send_item(FUNC_UNUSED, '1, '1);
    send_item(sli_pkg::FUNC_REMOVE, '1, '1);
    send_item(sli_pkg::FUNC_REMOVE, '0, 5'd5);
    for (int i = 0; i < 12; i++)
      send_item(sli_pkg::FUNC_INSERT,
                (i % 3 == 0) ? $urandom : int'($urandom_range(6)) - 3, '0);
    send_item(sli_pkg::FUNC_INSERT, 32'sd1, '0);
    send_item(sli_pkg::FUNC_REMOVE, '0, 5'(DEPTH));
    send_item(sli_pkg::FUNC_DUMP, '0, '0);

    send_random(40, 45, 30);

    // result side stalls long while commands keep coming
    rx_hold_reqs++;
    send_random(8, 50, 25);

    calm = 1'b1;
    send_random(40, 50, 25);
    calm = 1'b0;

    drain_results();

    send_random(40, 80, 10);
    send_random(30, 15, 70);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d inserts, %0d removes, %0d dumps, %0d unused-code items;",
             n_insert, n_remove, n_dump, n_unused);
    $display("%0d results checked, %0d inserts on a full list, long result stall included.",
             checked, n_full);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
